// ----- hdl/ats_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  // character classes, worked out at the input side
  typedef enum logic [3:0] {
    CC_END,
    CC_SPACE,
    CC_ALPHA,
    CC_DIGIT,
    CC_DOT,
    CC_UNDER,
    CC_PCT,
    CC_COMMA,
    CC_COLON,
    CC_OTHER
  } ch_class_e;

  typedef struct packed {
    ch_class_e  cls;
    logic [7:0] ch;
  } cls_word_t;

  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;

endpackage

`default_nettype wire

// ----- hdl/ats_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ats_front
  import ats_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire logic [7:0] ch_i,
  output logic           word_valid_o,
  output cls_word_t      word_o,
  input  wire logic      word_take_i
);

  cls_word_t            mem_q [CQ_DEPTH];
  logic [CQ_AW-1:0]     wptr_q, rptr_q;
  logic [CQ_AW:0]       cnt_q, cnt_d;
  cls_word_t            in_word;
  logic                 do_push, do_pop;

  always_comb begin
    in_word.ch = ch_i;
    if (ch_i == CH_NUL) begin
      in_word.cls = CC_END;
    end else if (ch_i == 8'h20 || (ch_i >= 8'h09 && ch_i <= 8'h0d)) begin
      in_word.cls = CC_SPACE;
    end else if ((ch_i >= 8'h61 && ch_i <= 8'h7a) || (ch_i >= 8'h41 && ch_i <= 8'h5a)) begin
      in_word.cls = CC_ALPHA;
    end else if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      in_word.cls = CC_DIGIT;
    end else if (ch_i == CH_DOT) begin
      in_word.cls = CC_DOT;
    end else if (ch_i == CH_UNDER) begin
      in_word.cls = CC_UNDER;
    end else if (ch_i == CH_PCT) begin
      in_word.cls = CC_PCT;
    end else if (ch_i == CH_COMMA) begin
      in_word.cls = CC_COMMA;
    end else if (ch_i == CH_COLON) begin
      in_word.cls = CC_COLON;
    end else begin
      in_word.cls = CC_OTHER;
    end
  end

  assign full_o       = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
  assign word_valid_o = (cnt_q != '0);
  assign word_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = word_take_i && word_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= in_word;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (CQ_AW+1)'(CQ_DEPTH))
    else $error("class queue overfilled");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("accepted word not counted");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("taken word not removed");

endmodule

`default_nettype wire

// ----- hdl/ats_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ats_back
  import ats_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       word_valid_i,
  input  wire cls_word_t  word_i,
  output logic            word_take_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [2:0]      tok_type_o,
  output logic [7:0]      tok_char_o,
  output logic            char_valid_o,
  output logic            first_of_token_o,
  output logic            last_of_token_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_REG,
    MODE_NUM
  } mode_e;

  typedef struct packed {
    logic [2:0] tok_type;
    logic [7:0] tok_char;
    logic       char_valid;
    logic       first;
    logic       last;
  } res_t;

  localparam logic [2:0] TOK_IDENT     = 3'd0;
  localparam logic [2:0] TOK_DIRECTIVE = 3'd1;
  localparam logic [2:0] TOK_REGISTER  = 3'd2;
  localparam logic [2:0] TOK_NUMBER    = 3'd3;
  localparam logic [2:0] TOK_COMMA     = 3'd4;
  localparam logic [2:0] TOK_COLON     = 3'd5;
  localparam logic [2:0] TOK_UNKNOWN   = 3'd6;
  localparam logic [2:0] TOK_END       = 3'd7;

  mode_e            mode_q, mode_d;
  logic [2:0]       ht_q, ht_d;
  logic [7:0]       hc_q, hc_d;
  logic             hv_q, hv_d;
  logic             hf_q, hf_d;

  res_t             rq_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wptr_q, rptr_q;
  logic [RQ_AW:0]   cnt_q, cnt_d;

  res_t             res_a, res_b, r0, r1;
  logic             a_ok, b_ok, ext_ok, take, do_pop;
  logic [1:0]       n_res;
  ch_class_e        cls;
  logic [7:0]       ch;
  res_t             head;

  assign cls = word_i.cls;
  assign ch  = word_i.ch;

  // room for two results is needed before a word is taken
  assign take   = word_valid_i && (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign do_pop = pop_i && !empty_o;
  assign word_take_o = take;

  always_comb begin
    ext_ok = 1'b0;
    case (mode_q)
      MODE_WORD: ext_ok = (cls == CC_ALPHA) || (cls == CC_DIGIT) ||
                          (cls == CC_DOT) || (cls == CC_UNDER);
      MODE_REG:  ext_ok = (cls == CC_ALPHA) || (cls == CC_DIGIT);
      MODE_NUM:  ext_ok = (cls == CC_DIGIT);
      default:   ext_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    ht_d   = ht_q;
    hc_d   = hc_q;
    hv_d   = hv_q;
    hf_d   = hf_q;
    a_ok   = 1'b0;
    b_ok   = 1'b0;
    res_a  = '{tok_type: ht_q, tok_char: hc_q, char_valid: 1'b1, first: hf_q, last: 1'b0};
    res_b  = '{tok_type: TOK_UNKNOWN, tok_char: ch, char_valid: 1'b1, first: 1'b1, last: 1'b1};
    if (take) begin
      if (ext_ok) begin
        // release the held character, keep the new one back
        a_ok = hv_q;
        hc_d = ch;
        hv_d = 1'b1;
        hf_d = !hv_q;
      end else begin
        if (mode_q != MODE_IDLE) begin
          a_ok = 1'b1;
          res_a.last = 1'b1;
          if (!hv_q) begin
            // register with no characters
            res_a = '{tok_type: TOK_REGISTER, tok_char: CH_NUL, char_valid: 1'b0,
                      first: 1'b1, last: 1'b1};
          end
        end
        mode_d = MODE_IDLE;
        ht_d   = '0;
        hc_d   = '0;
        hv_d   = 1'b0;
        hf_d   = 1'b0;
        case (cls)
          CC_END: begin
            b_ok  = 1'b1;
            res_b = '{tok_type: TOK_END, tok_char: CH_NUL, char_valid: 1'b0,
                      first: 1'b1, last: 1'b1};
          end
          CC_SPACE: ;
          CC_ALPHA, CC_DOT: begin
            mode_d = MODE_WORD;
            ht_d   = (cls == CC_DOT) ? TOK_DIRECTIVE : TOK_IDENT;
            hc_d   = ch;
            hv_d   = 1'b1;
            hf_d   = 1'b1;
          end
          CC_PCT: begin
            mode_d = MODE_REG;
            ht_d   = TOK_REGISTER;
            hf_d   = 1'b1;
          end
          CC_DIGIT: begin
            mode_d = MODE_NUM;
            ht_d   = TOK_NUMBER;
            hc_d   = ch;
            hv_d   = 1'b1;
            hf_d   = 1'b1;
          end
          CC_COMMA: begin
            b_ok           = 1'b1;
            res_b.tok_type = TOK_COMMA;
          end
          CC_COLON: begin
            b_ok           = 1'b1;
            res_b.tok_type = TOK_COLON;
          end
          default: b_ok = 1'b1;
        endcase
      end
    end
  end

  // pack the results so the first one goes in at the write pointer
  always_comb begin
    r0    = a_ok ? res_a : res_b;
    r1    = res_b;
    n_res = {1'b0, a_ok} + {1'b0, b_ok};
    cnt_d = cnt_q + (RQ_AW+1)'(n_res) - (RQ_AW+1)'(do_pop);
  end

  assign head             = rq_q[rptr_q];
  assign empty_o          = (cnt_q == '0);
  assign tok_type_o       = head.tok_type;
  assign tok_char_o       = head.tok_char;
  assign char_valid_o     = head.char_valid;
  assign first_of_token_o = head.first;
  assign last_of_token_o  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ht_q   <= '0;
      hc_q   <= '0;
      hv_q   <= 1'b0;
      hf_q   <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      ht_q   <= ht_d;
      hc_q   <= hc_d;
      hv_q   <= hv_d;
      hf_q   <= hf_d;
      cnt_q  <= cnt_d;
      wptr_q <= wptr_q + RQ_AW'(n_res);
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ok || b_ok) begin
      rq_q[wptr_q] <= r0;
    end
    if (a_ok && b_ok) begin
      rq_q[wptr_q + 1'b1] <= r1;
    end
  end

  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue overfilled");

  a_held_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> (mode_q != MODE_IDLE))
    else $error("held character outside a token");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cls == CC_END) |=> (mode_q == MODE_IDLE && !hv_q))
    else $error("end of text did not return to idle");

  a_num_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NUM) |-> (hv_q && ht_q == TOK_NUMBER))
    else $error("number mode without a held digit");

endmodule

`default_nettype wire

// ----- hdl/assembly_token_scanner.sv -----
// assembly token scanner
// input: one ascii character per word on ch_i, written with push while
//   full is low; character 0 ends the text
// output: one token character per word on tok_type_o, tok_char_o,
//   char_valid_o, first_of_token_o and last_of_token_o, shown while
//   empty is low and taken with pop
// a character may be pushed every cycle; each one gives zero, one or two
//   result words, so the sustained rate is one character per cycle as long
//   as results are drained at the rate they are made
// a result is registered first in the class queue and then in the result
//   queue; the last character of a token is held back until the next
//   character shows the token has ended
// the front classifies characters into a two-word queue; the back steps
//   the token state on one word per cycle when the four-word result queue
//   has room for two results
// when pop stays low the result queue fills, the back stops taking
//   words, and full rises once the class queue is full; nothing is lost
// reset empties both queues and returns the scanner to idle
`timescale 1ns / 1ps
`default_nettype none

module assembly_token_scanner
  import ats_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] ch_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      tok_type_o,
  output logic [7:0]      tok_char_o,
  output logic            char_valid_o,
  output logic            first_of_token_o,
  output logic            last_of_token_o
);

  logic      word_valid, word_take;
  cls_word_t word;

  ats_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .ch_i         (ch_i),
    .word_valid_o (word_valid),
    .word_o       (word),
    .word_take_i  (word_take)
  );

  ats_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .word_valid_i     (word_valid),
    .word_i           (word),
    .word_take_o      (word_take),
    .empty_o          (empty),
    .pop_i            (pop),
    .tok_type_o       (tok_type_o),
    .tok_char_o       (tok_char_o),
    .char_valid_o     (char_valid_o),
    .first_of_token_o (first_of_token_o),
    .last_of_token_o  (last_of_token_o)
  );

endmodule

`default_nettype wire
